FILE: hdl/rfe_pkg.sv
// rfe_pkg: shared constants, types and helper functions for the radix-2 FFT engine.
// Used by rfe_store, rfe_bfly and radix2_fft_engine; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rfe_pkg;

  localparam int MAX_LOG_LENGTH = 6;
  localparam int SAMPLE_WIDTH   = 16;

  localparam int ADDR_W  = MAX_LOG_LENGTH;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int CNT_W   = ADDR_W + 1;
  localparam int STORE_W = 24;
  localparam int LOG_W   = 3;

  // twiddle ROM: quarter wave of a 64-point cosine, Q1.15 with 1.0 as 32768
  localparam int ROM_LOG = 6;
  localparam int ROM_Q   = 1 << (ROM_LOG - 2);
  localparam int TWK_W   = ROM_LOG - 1;
  localparam int TW_W    = 17;
  localparam int FRAC_W  = 15;

  localparam int PROD_W = TW_W + STORE_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int T_W    = ACC_W - FRAC_W;
  localparam int SUM_W  = T_W + 1;

  localparam int IN_W         = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * STORE_W + ADDR_W;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LOG_W;
  localparam logic [LOG_W-1:0] LOG_RESET = LOG_W'(6);

  localparam logic [15:0] COS_ROM [ROM_Q+1] = '{
    16'd32768, 16'd32610, 16'd32138, 16'd31357, 16'd30274, 16'd28899,
    16'd27246, 16'd25330, 16'd23170, 16'd20788, 16'd18205, 16'd15447,
    16'd12540, 16'd9512,  16'd6393,  16'd3212,  16'd0
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOG_LENGTH,
    REG_INVERSE
  } cfg_reg_t;

  // butterfly unit micro-ops
  typedef enum logic [2:0] {
    BF_NOP,
    BF_LATCH,
    BF_MUL_RR,
    BF_MUL_II,
    BF_MUL_RI,
    BF_MUL_IR,
    BF_FIN
  } bf_op_t;

  typedef struct packed {
    logic signed [STORE_W-1:0] im;
    logic signed [STORE_W-1:0] re;
  } cplx_t;

  typedef struct packed {
    logic signed [TW_W-1:0] im;
    logic signed [TW_W-1:0] re;
  } tw_t;

  // twiddle for angle 2*pi*k/64; forward uses -sin, inverse the conjugate
  function automatic tw_t get_twiddle(input logic [TWK_W-1:0] k, input logic inv);
    logic [TWK_W-1:0] k_neg;
    logic [TW_W-1:0]  c;
    logic [TW_W-1:0]  s;
    tw_t              t;
    k_neg = -k;  // 32 - k, modulo 32
    if (k <= TWK_W'(ROM_Q)) begin
      c = TW_W'(COS_ROM[k]);
      s = TW_W'(COS_ROM[TWK_W'(ROM_Q) - k]);
    end else begin
      c = -TW_W'(COS_ROM[k_neg]);
      s = TW_W'(COS_ROM[k - TWK_W'(ROM_Q)]);
    end
    t.re = c;
    t.im = inv ? s : -s;
    return t;
  endfunction

  function automatic logic [STORE_W-1:0] sat_store(input logic [SUM_W-1:0] v);
    logic [SUM_W-STORE_W:0] hi;
    hi = v[SUM_W-1:STORE_W-1];
    if ((&hi) || !(|hi)) return v[STORE_W-1:0];
    else if (v[SUM_W-1]) return {1'b1, {(STORE_W-1){1'b0}}};
    else return {1'b0, {(STORE_W-1){1'b1}}};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/radix2_fft_engine.sv
// radix2_fft_engine: in-place radix-2 DIT FFT, N = 2^L points (L <= 6), one shared multiplier.
// Load: N input transactions at up to one per cycle. Compute: L*N/2 butterflies in turn, each
// stepped through read, latch, four multiplies (one 17x24 multiplier), finish and two writes.
// Emit: bins one at a time; the next bin is read only after out_tready takes the current one.
// Reset (rst_n, synchronous, active low): log_length = 6, inverse = 0, loading from sample 0.
// Depends on rfe_pkg, rfe_store, rfe_bfly.
`timescale 1ns / 1ps
`default_nettype none

module radix2_fft_engine (
  input  wire                            clk,
  input  wire                            rst_n,
  // input stream
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire [rfe_pkg::IN_W-1:0]        in_tdata,   // sample_re, sample_im
  // output stream
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [rfe_pkg::OUT_W-1:0]      out_tdata,  // bin_re, bin_im, bin_index, zero pad
  output logic                           out_tlast,  // last_bin
  // configuration write port
  input  wire                            cfg_we,
  input  wire [rfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [rfe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_BF_RD,    // addresses to store, twiddle lookup
    S_BF_LAT,   // read data into butterfly unit
    S_BF_M0,
    S_BF_M1,
    S_BF_M2,
    S_BF_M3,
    S_BF_FIN,
    S_BF_WR1,   // lower leg: a - t
    S_BF_WR0,   // upper leg: a + t, then advance indices
    S_EM_RD,
    S_EM_CAP,
    S_EM_OUT
  } state_t;

  state_t state_r;

  logic [rfe_pkg::LOG_W-1:0]  log_len_r;
  logic                       inverse_r;
  logic [rfe_pkg::CNT_W-1:0]  load_cnt_r;
  logic [rfe_pkg::LOG_W-1:0]  st_r;       // stage, 1..L
  logic [rfe_pkg::ADDR_W-1:0] j_r;        // twiddle group within stage
  logic [rfe_pkg::ADDR_W-1:0] i_r;        // upper leg index
  logic [rfe_pkg::ADDR_W-1:0] bin_cnt_r;
  rfe_pkg::tw_t               tw_r;

  logic                              out_tvalid_r;
  logic [rfe_pkg::STORE_W-1:0]       out_re_r;
  logic [rfe_pkg::STORE_W-1:0]       out_im_r;
  logic [rfe_pkg::ADDR_W-1:0]        out_idx_r;
  logic                              out_last_r;

  logic [rfe_pkg::LOG_W-1:0]  eff_log;
  logic [rfe_pkg::CNT_W-1:0]  n_pts;
  logic [rfe_pkg::CNT_W-1:0]  load_cnt_inc;
  logic [rfe_pkg::ADDR_W-1:0] rev_cnt;
  logic [rfe_pkg::ADDR_W-1:0] load_pos;
  logic [rfe_pkg::ADDR_W-1:0] l1;
  logic [rfe_pkg::CNT_W-1:0]  l2;
  logic [rfe_pkg::ADDR_W-1:0] i1;
  logic [rfe_pkg::CNT_W-1:0]  i_next;
  logic [rfe_pkg::ADDR_W-1:0] j_inc;
  logic [rfe_pkg::TWK_W-1:0]  tw_k;
  logic                       in_accept;

  logic                       mem_we;
  logic [rfe_pkg::ADDR_W-1:0] mem_waddr;
  rfe_pkg::cplx_t             mem_wdata;
  logic [rfe_pkg::ADDR_W-1:0] mem_raddr0;
  rfe_pkg::cplx_t             rd0;
  rfe_pkg::cplx_t             rd1;
  rfe_pkg::cplx_t             sample;
  rfe_pkg::cplx_t             bf_sum;
  rfe_pkg::cplx_t             bf_dif;
  rfe_pkg::bf_op_t            bf_op;

  // inverse scaling: divide by 2^sh, round half up
  function automatic logic [rfe_pkg::STORE_W-1:0] scale_bin(
    input logic signed [rfe_pkg::STORE_W-1:0] v,
    input logic [rfe_pkg::LOG_W-1:0] sh
  );
    logic signed [rfe_pkg::STORE_W:0] w;
    w = (rfe_pkg::STORE_W + 1)'(v);
    if (sh != '0) begin
      w = w + ((rfe_pkg::STORE_W + 1)'(1) << (sh - 1'b1));
    end
    w = w >>> sh;
    return w[rfe_pkg::STORE_W-1:0];
  endfunction

  // config writes block loading for that cycle; they also restart loading from sample 0.
  // Nothing is taken while reset is held.
  assign in_tready = rst_n && (state_r == S_LOAD) && !cfg_we;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    eff_log = (log_len_r > rfe_pkg::LOG_W'(rfe_pkg::MAX_LOG_LENGTH)) ?
              rfe_pkg::LOG_W'(rfe_pkg::MAX_LOG_LENGTH) : log_len_r;
    n_pts        = rfe_pkg::CNT_W'(1) << eff_log;
    load_cnt_inc = load_cnt_r + 1'b1;

    // bit-reversed load position over L bits
    for (int b = 0; b < rfe_pkg::ADDR_W; b++) begin
      rev_cnt[b] = load_cnt_r[rfe_pkg::ADDR_W-1-b];
    end
    load_pos = rev_cnt >> (rfe_pkg::LOG_W'(rfe_pkg::ADDR_W) - eff_log);

    l1     = rfe_pkg::ADDR_W'(1) << (st_r - 1'b1);
    l2     = rfe_pkg::CNT_W'(1) << st_r;
    i1     = i_r + l1;
    i_next = rfe_pkg::CNT_W'(i_r) + l2;
    j_inc  = j_r + 1'b1;
    // j < 2^(st-1), so the angle index always fits below 32
    tw_k   = rfe_pkg::TWK_W'(j_r << (rfe_pkg::LOG_W'(rfe_pkg::ROM_LOG) - st_r));

    sample.re = rfe_pkg::STORE_W'($signed(in_tdata[rfe_pkg::SAMPLE_WIDTH-1:0]));
    sample.im = rfe_pkg::STORE_W'($signed(
                  in_tdata[2*rfe_pkg::SAMPLE_WIDTH-1:rfe_pkg::SAMPLE_WIDTH]));
  end

  // store port muxing
  always_comb begin
    mem_we     = in_accept || (state_r == S_BF_WR1) || (state_r == S_BF_WR0);
    mem_waddr  = i_r;
    mem_wdata  = bf_sum;
    if (state_r == S_LOAD) begin
      mem_waddr = load_pos;
      mem_wdata = sample;
    end else if (state_r == S_BF_WR1) begin
      mem_waddr = i1;
      mem_wdata = bf_dif;
    end
    mem_raddr0 = (state_r == S_EM_RD) ? bin_cnt_r : i_r;
  end

  always_comb begin
    case (state_r)
      S_BF_LAT: bf_op = rfe_pkg::BF_LATCH;
      S_BF_M0:  bf_op = rfe_pkg::BF_MUL_RR;
      S_BF_M1:  bf_op = rfe_pkg::BF_MUL_II;
      S_BF_M2:  bf_op = rfe_pkg::BF_MUL_RI;
      S_BF_M3:  bf_op = rfe_pkg::BF_MUL_IR;
      S_BF_FIN: bf_op = rfe_pkg::BF_FIN;
      default:  bf_op = rfe_pkg::BF_NOP;
    endcase
  end

  rfe_store u_store (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr0 (mem_raddr0),
    .raddr1 (i1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  rfe_bfly u_bfly (
    .clk  (clk),
    .op   (bf_op),
    .tw   (tw_r),
    .a_in (rd0),
    .x_in (rd1),
    .sum  (bf_sum),
    .dif  (bf_dif)
  );

  // sequencer: load, stage/group/butterfly loops, emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      log_len_r    <= rfe_pkg::LOG_RESET;
      inverse_r    <= 1'b0;
      load_cnt_r   <= '0;
      st_r         <= '0;
      j_r          <= '0;
      i_r          <= '0;
      bin_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (rfe_pkg::cfg_reg_t'(cfg_index))
          rfe_pkg::REG_LOG_LENGTH: begin
            log_len_r  <= cfg_wdata;
            load_cnt_r <= '0;
          end
          rfe_pkg::REG_INVERSE: begin
            inverse_r  <= cfg_wdata[0];
            load_cnt_r <= '0;
          end
          default: ;
        endcase
      end

      case (state_r)
        S_LOAD: begin
          if (in_accept) begin
            if (load_cnt_inc == n_pts) begin
              load_cnt_r <= '0;
              st_r       <= rfe_pkg::LOG_W'(1);
              j_r        <= '0;
              i_r        <= '0;
              bin_cnt_r  <= '0;
              // single-point transform: nothing to butterfly
              state_r    <= (eff_log == '0) ? S_EM_RD : S_BF_RD;
            end else begin
              load_cnt_r <= load_cnt_inc;
            end
          end
        end
        S_BF_RD: begin
          tw_r    <= rfe_pkg::get_twiddle(tw_k, inverse_r);
          state_r <= S_BF_LAT;
        end
        S_BF_LAT: state_r <= S_BF_M0;
        S_BF_M0:  state_r <= S_BF_M1;
        S_BF_M1:  state_r <= S_BF_M2;
        S_BF_M2:  state_r <= S_BF_M3;
        S_BF_M3:  state_r <= S_BF_FIN;
        S_BF_FIN: state_r <= S_BF_WR1;
        S_BF_WR1: state_r <= S_BF_WR0;
        S_BF_WR0: begin
          if (i_next < n_pts) begin
            i_r     <= i_next[rfe_pkg::ADDR_W-1:0];
            state_r <= S_BF_RD;
          end else if (j_inc < l1) begin
            j_r     <= j_inc;
            i_r     <= j_inc;
            state_r <= S_BF_RD;
          end else if (st_r < eff_log) begin
            st_r    <= st_r + 1'b1;
            j_r     <= '0;
            i_r     <= '0;
            state_r <= S_BF_RD;
          end else begin
            bin_cnt_r <= '0;
            state_r   <= S_EM_RD;
          end
        end
        S_EM_RD: state_r <= S_EM_CAP;
        S_EM_CAP: begin
          out_re_r     <= inverse_r ? scale_bin(rd0.re, eff_log) : rd0.re;
          out_im_r     <= inverse_r ? scale_bin(rd0.im, eff_log) : rd0.im;
          out_idx_r    <= bin_cnt_r;
          out_last_r   <= (rfe_pkg::CNT_W'(bin_cnt_r) == n_pts - 1'b1);
          out_tvalid_r <= 1'b1;
          state_r      <= S_EM_OUT;
        end
        S_EM_OUT: begin
          if (out_tready) begin
            out_tvalid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_LOAD;
            end else begin
              bin_cnt_r <= bin_cnt_r + 1'b1;
              state_r   <= S_EM_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(rfe_pkg::OUT_W - rfe_pkg::OUT_FIELDS_W){1'b0}},
                       out_idx_r, out_im_r, out_re_r};

`ifndef SYNTHESIS
  a_load_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> !out_tvalid_r)
    else $error("output valid while loading");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_last_r) |-> (rfe_pkg::CNT_W'(out_idx_r) == n_pts - 1'b1))
    else $error("last bin flagged on wrong index");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tready && out_last_r) |=> (state_r == S_LOAD && load_cnt_r == '0))
    else $error("no return to loading after last bin");

  a_bf_legs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BF_RD) |-> (i1 > i_r && rfe_pkg::CNT_W'(i1) < n_pts))
    else $error("butterfly legs out of order or range");
`endif

endmodule

`default_nettype wire

FILE: hdl/rfe_store.sv
// rfe_store: sample/bin store, one write port and two registered read ports.
// Depends on rfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfe_store (
  input  wire                        clk,
  input  wire                        we,
  input  wire [rfe_pkg::ADDR_W-1:0]  waddr,
  input  wire rfe_pkg::cplx_t        wdata,
  input  wire [rfe_pkg::ADDR_W-1:0]  raddr0,
  input  wire [rfe_pkg::ADDR_W-1:0]  raddr1,
  output rfe_pkg::cplx_t             rdata0,
  output rfe_pkg::cplx_t             rdata1
);

  rfe_pkg::cplx_t mem_r [rfe_pkg::DEPTH];
  rfe_pkg::cplx_t rdata0_r;
  rfe_pkg::cplx_t rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata0_r <= mem_r[raddr0];
    rdata1_r <= mem_r[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

`default_nettype wire

FILE: hdl/rfe_bfly.sv
// rfe_bfly: shared butterfly datapath, one multiplier stepped through the complex product.
// Depends on rfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfe_bfly (
  input  wire                   clk,
  input  wire rfe_pkg::bf_op_t  op,
  input  wire rfe_pkg::tw_t     tw,
  input  wire rfe_pkg::cplx_t   a_in,
  input  wire rfe_pkg::cplx_t   x_in,
  output rfe_pkg::cplx_t        sum,
  output rfe_pkg::cplx_t        dif
);

  rfe_pkg::cplx_t a_r;
  rfe_pkg::cplx_t x_r;
  logic signed [rfe_pkg::TW_W-1:0]    mul_a;
  logic signed [rfe_pkg::STORE_W-1:0] mul_b;
  logic signed [rfe_pkg::PROD_W-1:0]  prod_r;
  logic signed [rfe_pkg::PROD_W-1:0]  acc_r;
  logic signed [rfe_pkg::ACC_W-1:0]   comb_v;
  logic signed [rfe_pkg::ACC_W-1:0]   rnd_v;
  logic signed [rfe_pkg::T_W-1:0]     tr_r;
  logic signed [rfe_pkg::T_W-1:0]     ti_r;

  // operand select: RR wr*xr, II wi*xi, RI wr*xi, IR wi*xr
  always_comb begin
    mul_a = (op == rfe_pkg::BF_MUL_RR || op == rfe_pkg::BF_MUL_RI) ? tw.re : tw.im;
    mul_b = (op == rfe_pkg::BF_MUL_RR || op == rfe_pkg::BF_MUL_IR) ? x_r.re : x_r.im;
  end

  // real part is a difference of products, imaginary a sum; round half up
  always_comb begin
    if (op == rfe_pkg::BF_MUL_RI) begin
      comb_v = rfe_pkg::ACC_W'(acc_r) - rfe_pkg::ACC_W'(prod_r);
    end else begin
      comb_v = rfe_pkg::ACC_W'(acc_r) + rfe_pkg::ACC_W'(prod_r);
    end
    rnd_v = (comb_v + rfe_pkg::ACC_W'(1 << (rfe_pkg::FRAC_W - 1))) >>> rfe_pkg::FRAC_W;
  end

  always_ff @(posedge clk) begin
    case (op)
      rfe_pkg::BF_LATCH: begin
        a_r <= a_in;
        x_r <= x_in;
      end
      rfe_pkg::BF_MUL_RR: begin
        prod_r <= mul_a * mul_b;
      end
      rfe_pkg::BF_MUL_II: begin
        acc_r  <= prod_r;
        prod_r <= mul_a * mul_b;
      end
      rfe_pkg::BF_MUL_RI: begin
        tr_r   <= rnd_v[rfe_pkg::T_W-1:0];
        prod_r <= mul_a * mul_b;
      end
      rfe_pkg::BF_MUL_IR: begin
        acc_r  <= prod_r;
        prod_r <= mul_a * mul_b;
      end
      rfe_pkg::BF_FIN: begin
        ti_r <= rnd_v[rfe_pkg::T_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    sum.re = rfe_pkg::sat_store(rfe_pkg::SUM_W'(a_r.re) + rfe_pkg::SUM_W'(tr_r));
    sum.im = rfe_pkg::sat_store(rfe_pkg::SUM_W'(a_r.im) + rfe_pkg::SUM_W'(ti_r));
    dif.re = rfe_pkg::sat_store(rfe_pkg::SUM_W'(a_r.re) - rfe_pkg::SUM_W'(tr_r));
    dif.im = rfe_pkg::sat_store(rfe_pkg::SUM_W'(a_r.im) - rfe_pkg::SUM_W'(ti_r));
  end

endmodule

`default_nettype wire
